// ===== src/spu_pkg.sv =====
package spu_pkg;

  localparam int MAX_STARS = 64;
  localparam int IDX_W     = $clog2(MAX_STARS);
  localparam int CNT_W     = 7;
  localparam int BOUND_W   = 21;

  // generator
  localparam logic [31:0] LCG_A        = 32'd1664525;
  localparam logic [31:0] LCG_C        = 32'd1013904223;
  localparam logic [31:0] SEED_DEFAULT = 32'h0D33_1F17;

  localparam int TICK_CLAMP = 200;

  // camera: both waves reduce to (ph * 8) / 125 over a half period
  localparam int          CAM_P1    = 6000;
  localparam int          CAM_P2    = 8000;
  localparam int          CAM_HALF1 = CAM_P1 / 2;
  localparam int          CAM_HALF2 = CAM_P2 / 2;
  localparam int          CAM_AMP1  = 96;
  localparam int          CAM_AMP2  = 128;
  localparam longint      PHASE_MOD = 64'h1_0000_0000;
  localparam int          CAM_WRAP1 = int'(PHASE_MOD % CAM_P1);
  localparam int          CAM_WRAP2 = int'(PHASE_MOD % CAM_P2);
  localparam logic [15:0] RECIP125  = 16'd33555;  // ceil(2^22 / 125)
  localparam logic [14:0] RECIP33   = 15'd31776;  // ceil(2^20 / 33)

  // pulse timing
  localparam int PULSE_CYC_WARP    = 12000;
  localparam int PULSE_LEN_WARP    = 1100;
  localparam int PULSE_CYC_GENTLE  = 15000;
  localparam int PULSE_LEN_GENTLE  = 760;
  localparam int PULSE_CYC_WARP_P  = 8000;
  localparam int PULSE_LEN_WARP_P  = 600;
  localparam int PULSE_CYC_GENT_P  = 10000;
  localparam int PULSE_LEN_GENT_P  = 420;
  localparam int PULSE_BOOST_WARP  = 18;
  localparam int PULSE_BOOST_GENT  = 8;

  // star geometry
  localparam int MARGIN        = 4096;   // 16 pixels in 8.8
  localparam int DRIFT_DIV     = 33000;
  localparam int FLY_MIN_SPX   = 48;
  localparam int FLY_MIN_SPY   = 32;
  localparam int FLY_Z_BASE    = 96;
  localparam int FLY_Z_RANGE   = 720;
  localparam int FLY_Z_MIN     = 24;
  localparam int LAYER_BOUND   = 3;
  localparam int TWINKLE_BOUND = 128;
  localparam int RIGHT_BOUND   = 48;

  // register field codes
  localparam logic       SCENE_PARALLAX = 1'b0;
  localparam logic       SCENE_FLY      = 1'b1;
  localparam logic [1:0] SPEED_CALM     = 2'd0;
  localparam logic [1:0] SPEED_SURGE    = 2'd2;
  localparam logic [1:0] CAM_DRIFT      = 2'd1;
  localparam logic [1:0] CAM_ARC        = 2'd2;
  localparam logic [1:0] PULSE_NONE     = 2'd0;
  localparam logic [1:0] PULSE_WARP     = 2'd1;

  typedef enum logic [2:0] {
    CFG_SCENE   = 3'd0,
    CFG_SPEED   = 3'd1,
    CFG_CAMERA  = 3'd2,
    CFG_PULSE   = 3'd3,
    CFG_PREVIEW = 3'd4,
    CFG_WIDTH   = 3'd5,
    CFG_HEIGHT  = 3'd6,
    CFG_COUNT   = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    DEST_LAYER   = 3'd0,
    DEST_TWINKLE = 3'd1,
    DEST_X       = 3'd2,
    DEST_X_RIGHT = 3'd3,
    DEST_Y       = 3'd4,
    DEST_X_FLY   = 3'd5,
    DEST_Y_FLY   = 3'd6,
    DEST_Z       = 3'd7
  } dest_e;

  typedef struct packed {
    logic        scene;
    logic [1:0]  speed;
    logic [1:0]  camera;
    logic [1:0]  pulse;
    logic        preview;
    logic [12:0] width;
    logic [12:0] height;
    logic [6:0]  count;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [9:0]         z;
    logic [1:0]         layer;
    logic [6:0]         twinkle;
  } star_t;

  typedef struct packed {
    logic             accept;
    logic             init;
    logic             prep;
    logic             rd;
    logic             load;
    logic             move2;
    logic             apply;
    logic             draw_start;
    dest_e            dest;
    logic             wr;
    logic [IDX_W-1:0] idx;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic draw_done;
    logic respawn;
    logic out_free;
  } sts_t;

  // base speed per scene and speed mode; preview column is 4/5, truncated
  function automatic logic [6:0] base_speed(logic fly, logic [1:0] spd, logic prev);
    logic [6:0] s;
    case (spd)
      SPEED_CALM:  s = fly ? (prev ? 7'd6  : 7'd8)  : (prev ? 7'd17 : 7'd22);
      SPEED_SURGE: s = fly ? (prev ? 7'd14 : 7'd18) : (prev ? 7'd38 : 7'd48);
      default:     s = fly ? (prev ? 7'd9  : 7'd12) : (prev ? 7'd27 : 7'd34);
    endcase
    return s;
  endfunction

endpackage

// ===== src/spu_draw.sv =====
module spu_draw (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        seed_load_i,
  input  logic [31:0]                 seed_i,
  input  logic                        start_i,
  input  logic [spu_pkg::BOUND_W-1:0] bound_i,
  output logic                        done_o,
  output logic [spu_pkg::BOUND_W-1:0] result_o
);
  import spu_pkg::*;

  logic [31:0]        rng_q, div_q;
  logic [BOUND_W-1:0] rem_q, bound_q;
  logic [5:0]         cnt_q;
  logic               busy_q, done_q;
  logic [31:0]        rng_step;
  logic [BOUND_W:0]   trial;
  logic               fits;

  assign rng_step = rng_q * LCG_A + LCG_C;
  assign trial    = {rem_q, div_q[31]};
  assign fits     = trial >= {1'b0, bound_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_q  <= SEED_DEFAULT;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (seed_load_i) begin
        rng_q <= (seed_i != '0) ? seed_i : SEED_DEFAULT;
      end
      if (start_i) begin
        rng_q  <= rng_step;
        cnt_q  <= 6'd32;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring remainder, one dividend bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q   <= rng_step;
      rem_q   <= '0;
      bound_q <= bound_i;
    end else if (busy_q) begin
      div_q <= {div_q[30:0], 1'b0};
      rem_q <= fits ? BOUND_W'(trial - {1'b0, bound_q}) : trial[BOUND_W-1:0];
    end
  end

  assign done_o   = done_q;
  assign result_o = rem_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("draw started while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> rem_q < bound_q)
    else $error("remainder not below bound");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> cnt_q != '0)
    else $error("busy with no bits left");

endmodule

// ===== src/spu_datapath.sv =====
module spu_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spu_pkg::cfg_t             cfg_i,
  input  spu_pkg::cmd_t             cmd_i,
  output spu_pkg::sts_t             sts_o,
  input  logic [31:0]               seed_i,
  input  logic [15:0]               tick_millis_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [spu_pkg::IDX_W-1:0] star_index_o,
  output logic signed [23:0]        pos_x_o,
  output logic signed [23:0]        pos_y_o,
  output logic [9:0]                depth_o,
  output logic [1:0]                layer_o,
  output logic [6:0]                twinkle_o,
  output logic                      last_o
);
  import spu_pkg::*;

  localparam logic signed [24:0] NEG_MARGIN = -25'(MARGIN);

  logic               fly;
  assign fly = (cfg_i.scene == SCENE_FLY);

  // ---------------- timers ----------------
  logic [31:0] phase_q;
  logic [12:0] r1_q, r2_q;        // phase modulo each camera period
  logic [13:0] pe_q;
  logic [10:0] pr_q;
  logic [7:0]  d_q, d_in;
  logic [32:0] phase_sum;
  logic [13:0] r1_sum, r2_sum;
  logic [14:0] pe_sum;
  logic [10:0] pr_dec;
  logic [13:0] cyc;
  logic [10:0] plen;
  logic        warp;

  assign d_in      = (tick_millis_i > 16'(TICK_CLAMP)) ? 8'(TICK_CLAMP) : tick_millis_i[7:0];
  assign phase_sum = {1'b0, phase_q} + 33'(d_in);
  assign r1_sum    = 14'(r1_q) + 14'(d_in) + (phase_sum[32] ? 14'(CAM_P1 - CAM_WRAP1) : 14'd0);
  assign r2_sum    = 14'(r2_q) + 14'(d_in) + (phase_sum[32] ? 14'(CAM_P2 - CAM_WRAP2) : 14'd0);
  assign pe_sum    = 15'(pe_q) + 15'(d_in);
  assign pr_dec    = (pr_q > 11'(d_in)) ? pr_q - 11'(d_in) : '0;
  assign warp      = (cfg_i.pulse == PULSE_WARP);
  assign cyc  = warp ? (cfg_i.preview ? 14'(PULSE_CYC_WARP_P) : 14'(PULSE_CYC_WARP))
                     : (cfg_i.preview ? 14'(PULSE_CYC_GENT_P) : 14'(PULSE_CYC_GENTLE));
  assign plen = warp ? (cfg_i.preview ? 11'(PULSE_LEN_WARP_P) : 11'(PULSE_LEN_WARP))
                     : (cfg_i.preview ? 11'(PULSE_LEN_GENT_P) : 11'(PULSE_LEN_GENTLE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      r1_q    <= '0;
      r2_q    <= '0;
      pe_q    <= '0;
      pr_q    <= '0;
    end else if (cmd_i.accept) begin
      if (cmd_i.init) begin
        phase_q <= '0;
        r1_q    <= '0;
        r2_q    <= '0;
        pe_q    <= '0;
        pr_q    <= '0;
      end else begin
        phase_q <= phase_sum[31:0];
        r1_q    <= (r1_sum >= 14'(CAM_P1)) ? 13'(r1_sum - 14'(CAM_P1)) : r1_sum[12:0];
        r2_q    <= (r2_sum >= 14'(CAM_P2)) ? 13'(r2_sum - 14'(CAM_P2)) : r2_sum[12:0];
        if (cfg_i.pulse == PULSE_NONE) begin
          pe_q <= '0;
          pr_q <= '0;
        end else if (pe_sum >= 15'(cyc)) begin
          pe_q <= '0;
          pr_q <= plen;
        end else begin
          pe_q <= pe_sum[13:0];
          pr_q <= pr_dec;
        end
      end
    end
  end

  // ---------------- per-tick speed and camera bias ----------------
  logic [6:0]         speed_q;
  logic signed [8:0]  bias_q;
  logic [12:0]        ph, half;
  logic [8:0]         amp;
  logic               up;
  logic [11:0]        nph;
  logic [30:0]        cprod;
  logic [8:0]         cq;
  logic signed [9:0]  bias_d;

  assign ph    = (cfg_i.camera == CAM_DRIFT) ? r1_q : r2_q;
  assign half  = (cfg_i.camera == CAM_DRIFT) ? 13'(CAM_HALF1) : 13'(CAM_HALF2);
  assign amp   = (cfg_i.camera == CAM_DRIFT) ? 9'(CAM_AMP1) : 9'(CAM_AMP2);
  assign up    = ph < half;
  assign nph   = up ? ph[11:0] : 12'(ph - half);
  assign cprod = {nph, 3'b000} * RECIP125;
  assign cq    = cprod[30:22];

  always_comb begin
    if (cfg_i.camera == CAM_DRIFT || cfg_i.camera == CAM_ARC) begin
      bias_d = up ? ($signed({1'b0, cq}) - $signed({1'b0, amp}))
                  : ($signed({1'b0, amp}) - $signed({1'b0, cq}));
    end else begin
      bias_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) d_q <= d_in;
    if (cmd_i.prep) begin
      speed_q <= base_speed(fly, cfg_i.speed, cfg_i.preview)
               + ((pr_q != '0) ? (warp ? 7'(PULSE_BOOST_WARP) : 7'(PULSE_BOOST_GENT)) : 7'd0);
      bias_q  <= bias_d[8:0];
    end
  end

  // ---------------- star table ----------------
  star_t            star_mem_q [MAX_STARS];
  star_t            rd_q, work_q, work_d, entry;
  logic [MAX_STARS-1:0] valid_q;
  logic             rdv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) star_mem_q[cmd_i.idx] <= work_q;
    if (cmd_i.rd) rd_q <= star_mem_q[cmd_i.idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rdv_q   <= 1'b0;
    end else begin
      if (cmd_i.accept && cmd_i.init) valid_q <= '0;
      if (cmd_i.wr) valid_q[cmd_i.idx] <= 1'b1;
      if (cmd_i.rd) rdv_q <= valid_q[cmd_i.idx];
    end
  end

  // entries not written since reset or the last init read as zero
  assign entry = rdv_q ? rd_q : '0;

  // ---------------- motion ----------------
  logic [4:0]  kl;
  logic [6:0]  sp;
  logic [7:0]  babs;
  logic [9:0]  bl;
  logic [14:0] p1_q;
  logic [17:0] pm_q;
  logic        neg_q;
  logic [29:0] qprod;
  logic [9:0]  q_q;
  logic signed [2:0] dy_q;
  logic [1:0]  dyq;

  assign kl   = fly ? {2'b00, entry.layer, 1'b0}
                    : ({entry.layer, 3'b000} + {2'b00, entry.layer, 1'b0});
  assign sp   = speed_q + 7'(kl);
  assign babs = bias_q[8] ? 8'(-bias_q) : bias_q[7:0];

  always_comb begin
    case (entry.layer)
      2'd0:    bl = '0;
      2'd1:    bl = 10'(babs);
      2'd2:    bl = {1'b0, babs, 1'b0};
      default: bl = {1'b0, babs, 1'b0} + 10'(babs);
    endcase
  end

  assign qprod = p1_q * RECIP33;
  assign dyq   = (pm_q >= 18'(2 * DRIFT_DIV)) ? 2'd2 : ((pm_q >= 18'(DRIFT_DIV)) ? 2'd1 : 2'd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p1_q  <= sp * d_q;
      pm_q  <= bl * d_q;
      neg_q <= bias_q[8];
    end
    if (cmd_i.move2) begin
      q_q  <= qprod[29:20];
      dy_q <= neg_q ? -$signed({1'b0, dyq}) : $signed({1'b0, dyq});
    end
  end

  logic signed [24:0] xn, yw, yn, span;
  logic signed [11:0] zn;

  assign xn   = {work_q.x[23], work_q.x} - 25'(q_q);
  assign yw   = {work_q.y[23], work_q.y} + {{22{dy_q[2]}}, dy_q};
  assign span = 25'({cfg_i.height, 8'b0}) + 25'(MARGIN);
  assign zn   = $signed({2'b00, work_q.z}) - $signed({2'b00, q_q});

  always_comb begin
    if (yw < NEG_MARGIN) yn = yw + span;
    else if (yw > span)  yn = yw - span;
    else                 yn = yw;
  end

  // ---------------- respawn draws ----------------
  logic [BOUND_W-1:0] bound, r;
  logic               draw_done;
  dest_e              dest_q;
  logic [14:0]        spx3, spx;
  logic [13:0]        spy2, spy;

  assign spx3 = {2'b00, cfg_i.width} + {1'b0, cfg_i.width, 1'b0};
  assign spx  = (spx3 < 15'(FLY_MIN_SPX)) ? 15'(FLY_MIN_SPX) : spx3;
  assign spy2 = {cfg_i.height, 1'b0};
  assign spy  = (spy2 < 14'(FLY_MIN_SPY)) ? 14'(FLY_MIN_SPY) : spy2;

  always_comb begin
    case (cmd_i.dest)
      DEST_LAYER:   bound = BOUND_W'(LAYER_BOUND);
      DEST_TWINKLE: bound = BOUND_W'(TWINKLE_BOUND);
      DEST_X_RIGHT: bound = BOUND_W'(RIGHT_BOUND);
      DEST_X:       bound = (cfg_i.width == '0) ? BOUND_W'(1) : {cfg_i.width, 8'b0};
      DEST_Y:       bound = (cfg_i.height == '0) ? BOUND_W'(1) : {cfg_i.height, 8'b0};
      DEST_X_FLY:   bound = BOUND_W'({spx, 1'b1});
      DEST_Y_FLY:   bound = BOUND_W'({spy, 1'b1});
      default:      bound = BOUND_W'(FLY_Z_RANGE);
    endcase
  end

  spu_draw u_draw (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_load_i (cmd_i.accept && cmd_i.init),
    .seed_i      (seed_i),
    .start_i     (cmd_i.draw_start),
    .bound_i     (bound),
    .done_o      (draw_done),
    .result_o    (r)
  );

  always_comb begin
    work_d = work_q;
    if (cmd_i.load) begin
      work_d = entry;
    end
    if (cmd_i.apply) begin
      if (fly) begin
        work_d.z = zn[9:0];
      end else begin
        work_d.x = xn[23:0];
        work_d.y = yn[23:0];
      end
    end
    if (draw_done) begin
      case (dest_q)
        DEST_LAYER: begin
          work_d.layer = r[1:0] + 2'd1;
          if (!fly) work_d.z = {8'b0, r[1:0] + 2'd1};
        end
        DEST_TWINKLE: work_d.twinkle = r[6:0];
        DEST_X:       work_d.x = {3'b000, r};
        DEST_X_RIGHT: work_d.x = {3'b000, cfg_i.width, 8'b0} + {10'b0, r[5:0], 8'b0};
        DEST_Y:       work_d.y = {3'b000, r};
        DEST_X_FLY:   work_d.x = {3'b000, r} - {9'b0, spx};
        DEST_Y_FLY:   work_d.y = {3'b000, r} - {10'b0, spy};
        default:      work_d.z = r[9:0] + 10'(FLY_Z_BASE);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (cmd_i.draw_start) dest_q <= cmd_i.dest;
  end

  // ---------------- result register ----------------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.wr) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      star_index_o <= cmd_i.idx;
      pos_x_o      <= work_q.x;
      pos_y_o      <= work_q.y;
      depth_o      <= work_q.z;
      layer_o      <= work_q.layer;
      twinkle_o    <= work_q.twinkle;
      last_o       <= cmd_i.last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sts_o.draw_done   = draw_done;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.respawn     = fly ? (zn < 12'(FLY_Z_MIN)) : (xn < NEG_MARGIN);

endmodule

// ===== src/spu_ctrl.sv =====
module spu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spu_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  input  logic          mode_i,
  output logic          in_ready_o,
  input  spu_pkg::sts_t sts_i,
  output spu_pkg::cmd_t cmd_o
);
  import spu_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_PREP     = 9'b000000010,
    ST_READ     = 9'b000000100,
    ST_MOVE1    = 9'b000001000,
    ST_MOVE2    = 9'b000010000,
    ST_MOVE3    = 9'b000100000,
    ST_DRAW     = 9'b001000000,
    ST_DRAWWAIT = 9'b010000000,
    ST_EMIT     = 9'b100000000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [2:0]       step_q, step_d;
  logic             right_q, right_d, init_q, init_d;
  logic [CNT_W-1:0] n;
  logic             last, fly, seq_last;
  dest_e            dest;

  assign fly  = (cfg_i.scene == SCENE_FLY);
  assign n    = (cfg_i.count > CNT_W'(MAX_STARS)) ? CNT_W'(MAX_STARS) : cfg_i.count;
  assign last = (CNT_W'(idx_q) + CNT_W'(1)) == n;

  // respawn draw order
  always_comb begin
    if (fly) begin
      case (step_q)
        3'd0:    dest = DEST_X_FLY;
        3'd1:    dest = DEST_Y_FLY;
        3'd2:    dest = DEST_Z;
        3'd3:    dest = DEST_LAYER;
        default: dest = DEST_TWINKLE;
      endcase
      seq_last = (step_q == 3'd4);
    end else begin
      case (step_q)
        3'd0:    dest = DEST_LAYER;
        3'd1:    dest = DEST_TWINKLE;
        3'd2:    dest = right_q ? DEST_X_RIGHT : DEST_X;
        default: dest = DEST_Y;
      endcase
      seq_last = (step_q == 3'd3);
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    step_d  = step_q;
    right_d = right_q;
    init_d  = init_q;
    cmd_o   = '0;
    cmd_o.idx  = idx_q;
    cmd_o.last = last;
    cmd_o.dest = dest;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cmd_o.init   = !mode_i;
          idx_d   = '0;
          step_d  = '0;
          right_d = 1'b0;
          init_d  = !mode_i;
          if (mode_i)        state_d = ST_PREP;
          else if (n == '0)  state_d = ST_IDLE;
          else               state_d = ST_DRAW;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = (n == '0) ? ST_IDLE : ST_READ;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_MOVE1;
      end
      ST_MOVE1: begin
        cmd_o.load = 1'b1;
        state_d    = ST_MOVE2;
      end
      ST_MOVE2: begin
        cmd_o.move2 = 1'b1;
        state_d     = ST_MOVE3;
      end
      ST_MOVE3: begin
        cmd_o.apply = 1'b1;
        if (sts_i.respawn) begin
          step_d  = '0;
          right_d = 1'b1;
          state_d = ST_DRAW;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DRAW: begin
        cmd_o.draw_start = 1'b1;
        state_d = ST_DRAWWAIT;
      end
      ST_DRAWWAIT: begin
        if (sts_i.draw_done) begin
          if (seq_last) begin
            state_d = ST_EMIT;
          end else begin
            step_d  = step_q + 3'd1;
            state_d = ST_DRAW;
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.wr = 1'b1;
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            step_d  = '0;
            right_d = 1'b0;
            state_d = init_q ? ST_DRAW : ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      step_q  <= '0;
      right_q <= 1'b0;
      init_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      right_q <= right_d;
      init_q  <= init_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_o.wr |-> sts_i.out_free && state_q == ST_EMIT)
    else $error("result written while result register is occupied");

endmodule

// ===== src/starfield_particle_update_core.sv =====
// Starfield particle update. Holds up to 64 stars and a 32-bit LCG. An init
// transfer (mode 0) reseeds the generator, clears the camera and pulse timers
// and respawns every active star; a tick transfer (mode 1) advances the timers
// by the elapsed time (clamped to 200 ms) and moves every active star. Either
// kind produces one result transfer per active star in index order, the last
// one flagged. Every random draw goes through a bit-serial remainder unit,
// one dividend bit per cycle. An init makes four draws per star in parallax
// and five in flythrough. A tick reads each star from the single-port star
// table and passes it through the three motion stages, plus one respawn
// sequence for each star that leaves the field. A new transfer is taken only
// after the last result of the previous one has been handed to the result
// register; that register lets the block idle-accept while the final result
// waits. Configuration writes are taken every cycle and must only be issued
// while the block is idle.
module starfield_particle_update_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [12:0]        cfg_data_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [31:0]        seed_i,
  input  logic [15:0]        tick_millis_i,
  // results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         star_index_o,
  output logic signed [23:0] pos_x_o,
  output logic signed [23:0] pos_y_o,
  output logic [9:0]         depth_o,
  output logic [1:0]         layer_o,
  output logic [6:0]         twinkle_o,
  output logic               last_o
);
  import spu_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  // register file; every index is a defined register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{width: 13'd640, height: 13'd480, count: 7'd48, default: '0};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SCENE:   cfg_q.scene   <= cfg_data_i[0];
        CFG_SPEED:   cfg_q.speed   <= cfg_data_i[1:0];
        CFG_CAMERA:  cfg_q.camera  <= cfg_data_i[1:0];
        CFG_PULSE:   cfg_q.pulse   <= cfg_data_i[1:0];
        CFG_PREVIEW: cfg_q.preview <= cfg_data_i[0];
        CFG_WIDTH:   cfg_q.width   <= cfg_data_i;
        CFG_HEIGHT:  cfg_q.height  <= cfg_data_i;
        CFG_COUNT:   cfg_q.count   <= cfg_data_i[6:0];
        default:     cfg_q         <= cfg_q;
      endcase
    end
  end

  // sequencer: walks the stars, orders the draws, paces the result register
  spu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // timers, star table, motion arithmetic, generator and result register
  spu_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .seed_i        (seed_i),
    .tick_millis_i (tick_millis_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .star_index_o  (star_index_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .depth_o       (depth_o),
    .layer_o       (layer_o),
    .twinkle_o     (twinkle_o),
    .last_o        (last_o)
  );

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import spu_pkg::*;

  localparam int LIMIT_CYCLES = 20000000;
  localparam int SETTLE       = 300;   // idle cycles before a register write
  localparam int IDLE_PCT     = 34;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [12:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               mode_i = 1'b0;
  logic [31:0]        seed_i = '0;
  logic [15:0]        tick_millis_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [5:0]         star_index_o;
  logic signed [23:0] pos_x_o;
  logic signed [23:0] pos_y_o;
  logic [9:0]         depth_o;
  logic [1:0]         layer_o;
  logic [6:0]         twinkle_o;
  logic               last_o;

  starfield_particle_update_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one reported star
  typedef struct packed {
    logic [5:0]  idx;
    logic [23:0] x;
    logic [23:0] y;
    logic [9:0]  z;
    logic [1:0]  layer;
    logic [6:0]  twinkle;
    logic        last;
  } star_rpt_t;

  star_rpt_t star_fifo[$];   // stars the block still owes us
  int        errors = 0;
  int        cycles = 0;
  bit        steady = 1'b0;  // no idling on either side while set
  int        hold_cycles = 0; // receiver hold-off requested by a test

  // ---------------------------------------------------------------------
  // shadow of the block: configuration, generator, timers, star table
  // ---------------------------------------------------------------------
  logic        m_scene;
  logic [1:0]  m_speed, m_camera, m_pulse;
  logic        m_preview;
  int unsigned m_width, m_height, m_count;
  logic [31:0] lcg;
  logic [31:0] cam_phase;
  int unsigned pulse_el, pulse_rem;
  int          st_x[MAX_STARS], st_y[MAX_STARS], st_z[MAX_STARS];
  int unsigned st_layer[MAX_STARS], st_tw[MAX_STARS];

  function automatic int unsigned lcg_draw(int unsigned bound);
    if (bound == 0) return 0;
    lcg = lcg * LCG_A + LCG_C;
    return lcg % bound;
  endfunction

  function automatic void spawn_side(int i, bit on_right);
    int wf, hf;
    wf = int'(m_width) * 256;
    hf = int'(m_height) * 256;
    st_layer[i] = 1 + lcg_draw(3);
    st_tw[i] = lcg_draw(128);
    if (on_right) st_x[i] = wf + int'(lcg_draw(48)) * 256;
    else          st_x[i] = int'(lcg_draw(wf > 0 ? wf : 1));
    st_y[i] = int'(lcg_draw(hf > 0 ? hf : 1));
    st_z[i] = int'(st_layer[i]);
  endfunction

  function automatic void spawn_deep(int i);
    int spx, spy;
    spx = int'(m_width) * 3;
    spy = int'(m_height) * 2;
    if (spx < 48) spx = 48;
    if (spy < 32) spy = 32;
    st_x[i] = int'(lcg_draw(spx * 2 + 1)) - spx;
    st_y[i] = int'(lcg_draw(spy * 2 + 1)) - spy;
    st_z[i] = 96 + int'(lcg_draw(720));
    st_layer[i] = 1 + lcg_draw(3);
    st_tw[i] = lcg_draw(128);
  endfunction

  function automatic longint cruise_speed();
    longint s;
    if (m_scene == SCENE_FLY)
      s = (m_speed == 2'd0) ? 8 : (m_speed == 2'd2) ? 18 : 12;
    else
      s = (m_speed == 2'd0) ? 22 : (m_speed == 2'd2) ? 48 : 34;
    if (m_preview) s = (s * 4) / 5;
    if (pulse_rem > 0) s += (m_pulse == PULSE_WARP) ? 18 : 8;
    return s;
  endfunction

  // triangle wave from -amp to +amp over one period
  function automatic longint sway(int unsigned period, int unsigned amp);
    int unsigned ph, half;
    ph = cam_phase % period;
    half = period / 2;
    if (ph < half) return -longint'(amp) + longint'((ph * (amp * 2)) / half);
    ph -= half;
    return longint'(amp) - longint'((ph * (amp * 2)) / half);
  endfunction

  function automatic void advance_pulse(int unsigned d);
    int unsigned cyc, plen;
    if (m_pulse == PULSE_NONE) begin
      pulse_el = 0;
      pulse_rem = 0;
      return;
    end
    pulse_el += d;
    pulse_rem = (pulse_rem > d) ? pulse_rem - d : 0;
    if (m_pulse == PULSE_WARP) begin
      cyc = m_preview ? 8000 : 12000;
      plen = m_preview ? 600 : 1100;
    end else begin
      cyc = m_preview ? 10000 : 15000;
      plen = m_preview ? 420 : 760;
    end
    if (pulse_el >= cyc) begin
      pulse_el = 0;
      pulse_rem = plen;
    end
  endfunction

  // apply one accepted item to the shadow and queue the stars it reports
  function automatic void predict_frame(bit is_tick, logic [31:0] seed,
                                        logic [15:0] ms);
    int unsigned n, d;
    longint spd, bias, x, y, l, span;
    star_rpt_t r;
    n = (m_count > MAX_STARS) ? MAX_STARS : m_count;
    if (!is_tick) begin
      lcg = (seed != 0) ? seed : SEED_DEFAULT;
      for (int i = 0; i < MAX_STARS; i++) begin
        if (i < n) begin
          if (m_scene == SCENE_FLY) spawn_deep(i);
          else spawn_side(i, 1'b0);
        end else begin
          st_x[i] = 0; st_y[i] = 0; st_z[i] = 0; st_layer[i] = 0; st_tw[i] = 0;
        end
      end
      cam_phase = 0;
      pulse_el = 0;
      pulse_rem = 0;
    end else begin
      d = (ms > 200) ? 200 : ms;
      cam_phase += d;
      advance_pulse(d);
      spd = cruise_speed();
      if (m_scene == SCENE_FLY) begin
        for (int i = 0; i < n; i++) begin
          st_z[i] -= int'(((spd + longint'(st_layer[i]) * 2) * longint'(d)) / 33);
          if (st_z[i] < 24) spawn_deep(i);
        end
      end else begin
        bias = 0;
        if (m_camera == CAM_DRIFT) bias = sway(6000, 96);
        else if (m_camera == CAM_ARC) bias = sway(8000, 128);
        span = longint'(m_height) * 256 + 4096;
        for (int i = 0; i < n; i++) begin
          x = st_x[i]; y = st_y[i]; l = st_layer[i];
          x -= ((spd + l * 10) * longint'(d)) / 33;
          y += (bias * l * longint'(d)) / 33000;
          if (x < -4096) begin
            spawn_side(i, 1'b1);   // left the field: back in on the right edge
            continue;
          end
          if (y < -4096) y += span;
          else if (y > span) y -= span;
          st_x[i] = int'(x);
          st_y[i] = int'(y);
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r.idx = i[5:0];
      r.x = st_x[i][23:0];
      r.y = st_y[i][23:0];
      r.z = st_z[i][9:0];
      r.layer = st_layer[i][1:0];
      r.twinkle = st_tw[i][6:0];
      r.last = (i + 1 == n);
      star_fifo.push_back(r);
    end
  endfunction

  function automatic void shadow_write(cfg_reg_e idx, logic [12:0] v);
    case (idx)
      CFG_SCENE:   m_scene = v[0];
      CFG_SPEED:   m_speed = v[1:0];
      CFG_CAMERA:  m_camera = v[1:0];
      CFG_PULSE:   m_pulse = v[1:0];
      CFG_PREVIEW: m_preview = v[0];
      CFG_WIDTH:   m_width = v;
      CFG_HEIGHT:  m_height = v;
      CFG_COUNT:   m_count = v[6:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------
  function automatic bit want_idle();
    return !steady && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // one item transfer; valid stays up across back-to-back items
  task automatic send_frame(bit is_tick, logic [31:0] seed, logic [15:0] ms);
    if (want_idle()) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (want_idle());
    end
    in_valid_i <= 1'b1;
    mode_i <= is_tick;
    seed_i <= seed;
    tick_millis_i <= ms;
    do @(posedge clk_i); while (!in_ready_o);
    predict_frame(is_tick, seed, ms);
  endtask

  task automatic send_tick();
    logic [15:0] ms;
    ms = ($urandom_range(1) != 0) ? 16'($urandom_range(200)) : 16'($urandom);
    send_frame(1'b1, $urandom, ms);
  endtask

  task automatic send_init();
    send_frame(1'b0, $urandom, 16'($urandom));
  endtask

  // wait until every star is back and the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (star_fifo.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // valid stays up across back-to-back writes; the caller drops it
  task automatic write_reg(cfg_reg_e idx, logic [12:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_write(idx, v);
  endtask

  task automatic write_all(logic scene, logic [1:0] spd, logic [1:0] cam, logic [1:0] pls,
                           logic prv, logic [12:0] w, logic [12:0] h, logic [12:0] cnt);
    write_reg(CFG_SCENE, {12'($urandom), scene});
    write_reg(CFG_SPEED, {11'($urandom), spd});
    write_reg(CFG_CAMERA, {11'($urandom), cam});
    write_reg(CFG_PULSE, {11'($urandom), pls});
    write_reg(CFG_PREVIEW, {12'($urandom), prv});
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_COUNT, cnt);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver: random stalls, or a long hold-off when a test asks for one
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // result checker: each star transfer against the oldest expectation
  always @(posedge clk_i) begin
    star_rpt_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (star_fifo.size() == 0) begin
        errors++;
        $display("%0t: unexpected star %0d", $time, star_index_o);
      end else begin
        e = star_fifo.pop_front();
        if (e.idx !== star_index_o) begin
          errors++;
          $display("%0t: star_index exp %0d got %0d", $time, e.idx, star_index_o);
        end
        if (e.x !== pos_x_o) begin
          errors++;
          $display("%0t: pos_x exp %h got %h", $time, e.x, pos_x_o);
        end
        if (e.y !== pos_y_o) begin
          errors++;
          $display("%0t: pos_y exp %h got %h", $time, e.y, pos_y_o);
        end
        if (e.z !== depth_o) begin
          errors++;
          $display("%0t: depth exp %0d got %0d", $time, e.z, depth_o);
        end
        if (e.layer !== layer_o) begin
          errors++;
          $display("%0t: layer exp %0d got %0d", $time, e.layer, layer_o);
        end
        if (e.twinkle !== twinkle_o) begin
          errors++;
          $display("%0t: twinkle exp %0d got %0d", $time, e.twinkle, twinkle_o);
        end
        if (e.last !== last_o) begin
          errors++;
          $display("%0t: last exp %0d got %0d", $time, e.last, last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // ticks before any init move the all-zero table (layer reads zero)
  task automatic test_cold_table();
    steady = 1'b1;
    send_frame(1'b1, 32'hFFFF_FFFF, 16'd200);
    send_frame(1'b1, 32'h0, 16'hFFFF);
    steady = 1'b0;
    settle();
  endtask

  // seed zero and all ones, tick extremes, degenerate field and counts,
  // and the unused code of every mode field
  task automatic test_edges();
    send_frame(1'b0, 32'h0, 16'hFFFF);
    send_frame(1'b1, 32'h0, 16'd0);
    send_frame(1'b1, 32'h0, 16'd201);
    send_frame(1'b0, 32'hFFFF_FFFF, 16'd0);
    send_frame(1'b1, 32'h1234_5678, 16'hFFFF);
    settle();
    write_all(SCENE_PARALLAX, 2'd3, 2'd3, 2'd3, 1'b1, 13'd0, 13'd0, 13'd5);
    send_init();
    send_tick();
    send_tick();
    settle();
    write_all(SCENE_FLY, 2'd3, CAM_DRIFT, 2'd3, 1'b0, 13'd0, 13'd0, 13'd3);
    send_init();
    send_tick();
    send_tick();
    settle();
    // star count far beyond the table saturates, then drops to none
    write_all(SCENE_FLY, SPEED_SURGE, CAM_ARC, PULSE_WARP, 1'b1, 13'h1FFF,
              13'h1FFF, 13'h1FFF);
    send_init();
    send_tick();
    settle();
    write_reg(CFG_COUNT, 13'h1F80);   // low 7 bits zero: no stars reported
    cfg_valid_i <= 1'b0;
    send_init();
    send_tick();
    settle();
    write_all(SCENE_PARALLAX, SPEED_CALM, CAM_ARC, PULSE_NONE, 1'b0, 13'd4096,
              13'd4096, 13'd64);
    send_init();
    send_tick();
    send_tick();
    settle();
  endtask

  // receiver holds off long enough for the block to stop taking items
  task automatic test_backpressure();
    write_all(SCENE_PARALLAX, SPEED_SURGE, CAM_DRIFT, PULSE_WARP, 1'b0, 13'd320,
              13'd200, 13'd8);
    send_init();
    hold_cycles <= 2000;
    repeat (6) send_tick();
    settle();
  endtask

  // long run of ticks so the pulse timer fires and the camera turns around
  task automatic test_pulse_cycle();
    write_all(SCENE_PARALLAX, SPEED_CALM, CAM_DRIFT, PULSE_WARP, 1'b1, 13'd160,
              13'd120, 13'd4);
    send_init();
    steady = 1'b1;
    repeat (24) send_frame(1'b1, $urandom, 16'($urandom_range(200, 65535)));
    steady = 1'b0;
    repeat (24) send_tick();
    settle();
  endtask

  // random settings, an init, then a burst of ticks with random content
  task automatic test_random_scenes();
    logic [12:0] cnt;
    for (int p = 0; p < 7; p++) begin
      case ($urandom_range(9))
        0:       cnt = 13'd0;
        1:       cnt = 13'($urandom_range(64, 127));
        default: cnt = 13'($urandom_range(1, 12));
      endcase
      cnt[12:7] = 6'($urandom);
      write_all(1'($urandom), 2'($urandom), 2'($urandom), 2'($urandom), 1'($urandom),
                ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 800)),
                ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 600)),
                cnt);
      send_init();
      repeat ($urandom_range(8, 14)) begin
        if ($urandom_range(15) == 0) send_init();
        else send_tick();
      end
      settle();
    end
  endtask

  initial begin
    m_scene = SCENE_PARALLAX; m_speed = '0; m_camera = '0; m_pulse = '0;
    m_preview = 1'b0; m_width = 640; m_height = 480; m_count = 48;
    lcg = SEED_DEFAULT; cam_phase = 0; pulse_el = 0; pulse_rem = 0;
    for (int i = 0; i < MAX_STARS; i++) begin
      st_x[i] = 0; st_y[i] = 0; st_z[i] = 0; st_layer[i] = 0; st_tw[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_cold_table();
    test_edges();
    test_backpressure();
    test_pulse_cycle();
    test_random_scenes();
    settle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/spu_pkg.sv
src/spu_draw.sv
src/spu_datapath.sv
src/spu_ctrl.sv
src/starfield_particle_update_core.sv
bench/tb_top.sv
